/* hw/rtl/tcw_pkg.sv */
// Shared types and constants of the text console writer.
package tcw_pkg;

    localparam int C_COLUMNS  = 80;
    localparam int C_ROWS     = 25;
    localparam int C_KIND_W   = 3;
    localparam int C_CHAR_W   = 8;
    localparam int C_COLOR_W  = 4;
    localparam int C_CFG_IDX_W = 1;

    localparam logic [C_CHAR_W-1:0]  C_NEWLINE  = 8'd10;
    localparam logic [C_COLOR_W-1:0] C_FG_RESET = 4'd15;
    localparam logic [C_COLOR_W-1:0] C_BG_RESET = 4'd0;

    localparam logic [C_CFG_IDX_W-1:0] CFG_FOREGROUND = 1'b0;
    localparam logic [C_CFG_IDX_W-1:0] CFG_BACKGROUND = 1'b1;

    typedef enum logic [C_KIND_W-1:0] {
        K_WRITE       = 3'd0,
        K_MOVE_RC     = 3'd1,
        K_MOVE_ABS    = 3'd2,
        K_FILL_SCREEN = 3'd3,
        K_FILL_ROW    = 3'd4,
        K_CLEAR       = 3'd5,
        K_READ        = 3'd6,
        K_NOP         = 3'd7
    } t_kind;

    typedef struct packed {
        logic [C_CHAR_W-1:0]  code;
        logic [C_COLOR_W-1:0] fg;
        logic [C_COLOR_W-1:0] bg;
    } t_cell;

    localparam int C_CELL_W = $bits(t_cell);

    typedef enum logic [3:0] {
        S_IDLE,
        S_NL,
        S_MUL,
        S_CLAMP,
        S_CHECK,
        S_COPY,
        S_COPY_END,
        S_FILL,
        S_RD,
        S_RD_WAIT,
        S_FINISH
    } t_state;

endpackage

/* hw/rtl/tcw_ram.sv */
// Generic simple dual-port RAM with registered read.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/text_console_writer_unit.sv */
// Text console writer: screen store, cursor and operation sequencer.
//
//  Channel  | Dir | Handshake               | Payload
//  ---------+-----+-------------------------+----------------------------------------------
//  request  | in  | i_in_valid / o_in_stall | i_kind i_char_code i_row i_column i_position
//  result   | out | o_out_valid/ i_out_stall| o_cursor_position o_cell_char o_cell_fg/bg
//  config   | in  | i_cfg_we                | i_cfg_index i_cfg_data
//
//  A newline first searches for the next line start; fills, clears and each scroll
//  move cells through the single RAM write port.
//  o_in_stall is high from acceptance until the result is loaded into the output
//  register; a request may be taken while that result still waits.
//  Reset is synchronous, active low; the screen store is not cleared.
module text_console_writer_unit #(
    parameter int COLUMNS = tcw_pkg::C_COLUMNS,
    parameter int ROWS    = tcw_pkg::C_ROWS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [tcw_pkg::C_KIND_W-1:0]        i_kind,
    input  logic [tcw_pkg::C_CHAR_W-1:0]        i_char_code,
    input  logic [$clog2(ROWS)-1:0]             i_row,
    input  logic [$clog2(COLUMNS)-1:0]          i_column,
    input  logic [$clog2(ROWS*COLUMNS)-1:0]     i_position,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [$clog2(ROWS*COLUMNS+1)-1:0]   o_cursor_position,
    output logic [tcw_pkg::C_CHAR_W-1:0]        o_cell_char,
    output logic [tcw_pkg::C_COLOR_W-1:0]       o_cell_foreground,
    output logic [tcw_pkg::C_COLOR_W-1:0]       o_cell_background,
    input  logic                                i_cfg_we,
    input  logic [tcw_pkg::C_CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tcw_pkg::C_COLOR_W-1:0]       i_cfg_data
);

    import tcw_pkg::*;

    localparam int SIZE    = ROWS * COLUMNS;
    localparam int A_W     = $clog2(SIZE);
    localparam int ROW_W   = $clog2(ROWS);
    localparam int COL_W   = $clog2(COLUMNS);
    localparam int OUT_W   = $clog2(SIZE + 1);
    localparam int CUR_W   = $clog2(SIZE + COLUMNS + 1);
    localparam int M_W     = ROW_W + COL_W + 1;
    localparam int AC_W    = (M_W > CUR_W) ? M_W : CUR_W;

    localparam logic [A_W-1:0]   A_SCREEN_LAST = A_W'(SIZE - 1);
    localparam logic [A_W-1:0]   A_ROW_LAST    = A_W'(COLUMNS - 1);
    localparam logic [A_W-1:0]   A_COPY_LAST   = A_W'(SIZE - COLUMNS - 1);
    localparam logic [A_W-1:0]   A_LAST_LINE   = A_W'(SIZE - COLUMNS);
    localparam logic [A_W-1:0]   A_COLUMNS     = A_W'(COLUMNS);
    localparam logic [CUR_W-1:0] CUR_SIZE      = CUR_W'(SIZE);
    localparam logic [CUR_W-1:0] CUR_COLUMNS   = CUR_W'(COLUMNS);
    localparam logic [AC_W-1:0]  AC_SIZE       = AC_W'(SIZE);
    localparam logic [AC_W-1:0]  AC_COLUMNS    = AC_W'(COLUMNS);

    t_state               r_state, n_state;
    logic                 r_out_valid, n_out_valid;
    logic [OUT_W-1:0]     r_out_cursor, n_out_cursor;
    t_cell                r_out_cell, n_out_cell;
    logic [CUR_W-1:0]     r_cursor, n_cursor;
    logic [C_COLOR_W-1:0] r_fg, n_fg;
    logic [C_COLOR_W-1:0] r_bg, n_bg;
    logic                 r_pend, n_pend;
    logic [A_W-1:0]       r_pend_addr, n_pend_addr;
    logic [A_W-1:0]       r_addr, n_addr;
    logic [A_W-1:0]       r_cnt, n_cnt;
    logic [AC_W-1:0]      r_acc, n_acc;
    t_cell                r_wdata, n_wdata;
    t_cell                r_rd, n_rd;
    t_kind                r_kind, n_kind;
    logic [ROW_W-1:0]     r_row, n_row;
    logic [COL_W-1:0]     r_col, n_col;
    logic                 r_scroll, n_scroll;

    logic                 ram_we;
    logic [A_W-1:0]       ram_waddr;
    logic [C_CELL_W-1:0]  ram_wdata;
    logic [A_W-1:0]       ram_raddr;
    logic [C_CELL_W-1:0]  ram_rdata;
    logic [AC_W-1:0]      row_base;
    t_kind                in_kind;

    assign in_kind  = t_kind'(i_kind);
    assign row_base = AC_W'(r_row) * AC_COLUMNS;

    tcw_ram #(
        .WIDTH (C_CELL_W),
        .DEPTH (SIZE)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cursor    <= '0;
            r_fg        <= C_FG_RESET;
            r_bg        <= C_BG_RESET;
            r_pend      <= 1'b0;
            r_scroll    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_cursor    <= n_cursor;
            r_fg        <= n_fg;
            r_bg        <= n_bg;
            r_pend      <= n_pend;
            r_scroll    <= n_scroll;
        end
        r_out_cursor <= n_out_cursor;
        r_out_cell   <= n_out_cell;
        r_pend_addr  <= n_pend_addr;
        r_addr       <= n_addr;
        r_cnt        <= n_cnt;
        r_acc        <= n_acc;
        r_wdata      <= n_wdata;
        r_rd         <= n_rd;
        r_kind       <= n_kind;
        r_row        <= n_row;
        r_col        <= n_col;
    end

    always_comb begin
        n_state      = r_state;
        n_out_valid  = r_out_valid;
        n_out_cursor = r_out_cursor;
        n_out_cell   = r_out_cell;
        n_cursor     = r_cursor;
        n_fg         = r_fg;
        n_bg         = r_bg;
        n_pend       = 1'b0;
        n_pend_addr  = r_addr;
        n_addr       = r_addr;
        n_cnt        = r_cnt;
        n_acc        = r_acc;
        n_wdata      = r_wdata;
        n_rd         = r_rd;
        n_kind       = r_kind;
        n_row        = r_row;
        n_col        = r_col;
        n_scroll     = r_scroll;
        ram_raddr    = r_addr;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FOREGROUND: n_fg = i_cfg_data;
                CFG_BACKGROUND: n_bg = i_cfg_data;
                default: ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_wdata  = '{code: i_char_code, fg: r_fg, bg: r_bg};
                    n_rd     = '0;
                    n_kind   = in_kind;
                    n_row    = i_row;
                    n_col    = i_column;
                    n_acc    = '0;
                    n_scroll = 1'b0;
                    unique case (in_kind)
                        K_WRITE: begin
                            n_state = (i_char_code == C_NEWLINE) ? S_NL : S_CHECK;
                        end
                        K_MOVE_RC: n_state = S_MUL;
                        K_MOVE_ABS: begin
                            n_cursor = (CUR_W'(i_position) > CUR_SIZE) ? CUR_SIZE
                                                                       : CUR_W'(i_position);
                            n_state  = S_FINISH;
                        end
                        K_FILL_SCREEN: begin
                            n_addr  = '0;
                            n_cnt   = A_SCREEN_LAST;
                            n_state = S_FILL;
                        end
                        K_FILL_ROW: begin
                            n_state = ((ROW_W + 1)'(i_row) < (ROW_W + 1)'(ROWS)) ? S_MUL
                                                                                 : S_FINISH;
                        end
                        K_CLEAR: begin
                            n_wdata.code = '0;
                            n_cursor     = '0;
                            n_addr       = '0;
                            n_cnt        = A_SCREEN_LAST;
                            n_state      = S_FILL;
                        end
                        K_READ: begin
                            n_addr  = i_position;
                            n_state = (CUR_W'(i_position) < CUR_SIZE) ? S_RD : S_FINISH;
                        end
                        default: n_state = S_FINISH;
                    endcase
                end
            end
            // next line start: first multiple of COLUMNS above the cursor
            S_NL: begin
                if (r_acc > AC_W'(r_cursor)) begin
                    n_cursor = r_acc[CUR_W-1:0];
                    n_state  = S_CHECK;
                end else begin
                    n_acc = r_acc + AC_COLUMNS;
                end
            end
            S_MUL: begin
                if (r_kind == K_FILL_ROW) begin
                    n_addr  = row_base[A_W-1:0];
                    n_cnt   = A_ROW_LAST;
                    n_state = S_FILL;
                end else begin
                    n_acc   = row_base + AC_W'(r_col);
                    n_state = S_CLAMP;
                end
            end
            S_CLAMP: begin
                n_cursor = (r_acc > AC_SIZE) ? CUR_SIZE : r_acc[CUR_W-1:0];
                n_state  = S_FINISH;
            end
            S_CHECK: begin
                if (r_cursor >= CUR_SIZE) begin
                    n_cursor = r_cursor - CUR_COLUMNS;
                    n_addr   = '0;
                    n_cnt    = A_COPY_LAST;
                    n_scroll = 1'b1;
                    n_state  = S_COPY;
                end else begin
                    if (r_wdata.code != C_NEWLINE) begin
                        n_cursor = r_cursor + CUR_W'(1);
                    end
                    n_state = S_FINISH;
                end
            end
            // scroll copy: read line below, write it back in the following cycle
            S_COPY: begin
                ram_raddr   = r_addr + A_COLUMNS;
                n_pend      = 1'b1;
                n_pend_addr = r_addr;
                n_addr      = r_addr + A_W'(1);
                n_cnt       = r_cnt - A_W'(1);
                if (r_cnt == '0) begin
                    n_state = S_COPY_END;
                end
            end
            S_COPY_END: begin
                n_addr  = A_LAST_LINE;
                n_cnt   = A_ROW_LAST;
                n_state = S_FILL;
            end
            S_FILL: begin
                n_addr = r_addr + A_W'(1);
                n_cnt  = r_cnt - A_W'(1);
                if (r_cnt == '0) begin
                    n_scroll = 1'b0;
                    n_state  = r_scroll ? S_CHECK : S_FINISH;
                end
            end
            S_RD: begin
                n_state = S_RD_WAIT;
            end
            S_RD_WAIT: begin
                n_rd    = t_cell'(ram_rdata);
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_cursor = r_cursor[OUT_W-1:0];
                    n_out_cell   = r_rd;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_addr;
        ram_wdata = r_wdata;
        priority if (r_pend) begin
            ram_we    = 1'b1;
            ram_waddr = r_pend_addr;
            ram_wdata = ram_rdata;
        end else if (r_state == S_FILL) begin
            ram_we    = 1'b1;
            ram_wdata = r_scroll ? '0 : r_wdata;
        end else if (r_state == S_CHECK && r_cursor < CUR_SIZE
                     && r_wdata.code != C_NEWLINE) begin
            ram_we    = 1'b1;
            ram_waddr = r_cursor[A_W-1:0];
        end else begin
            ram_we = 1'b0;
        end
    end

    assign o_in_stall        = (r_state != S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_cursor_position = r_out_cursor;
    assign o_cell_char       = r_out_cell.code;
    assign o_cell_foreground = r_out_cell.fg;
    assign o_cell_background = r_out_cell.bg;

endmodule

/* hw/rtl/tcw_checker.sv */
// Port-level checks of the text console writer, bound to the top level.
module tcw_checker #(
    parameter int COLUMNS = tcw_pkg::C_COLUMNS,
    parameter int ROWS    = tcw_pkg::C_ROWS
) (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_stall,
    input logic                                o_out_valid,
    input logic                                i_out_stall,
    input logic [$clog2(ROWS*COLUMNS+1)-1:0]   o_cursor_position,
    input logic [tcw_pkg::C_CHAR_W-1:0]        o_cell_char,
    input logic [tcw_pkg::C_COLOR_W-1:0]       o_cell_foreground,
    input logic [tcw_pkg::C_COLOR_W-1:0]       o_cell_background
);

    localparam int OUT_W = $clog2(ROWS * COLUMNS + 1);
    localparam logic [OUT_W-1:0] OUT_SIZE = OUT_W'(ROWS * COLUMNS);

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("outputs not quiet after reset");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request accepted without going busy");

    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a request in progress");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_cursor_position <= OUT_SIZE))
        else $error("cursor beyond screen end");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_cursor_position) && $stable(o_cell_char)
             && $stable(o_cell_foreground) && $stable(o_cell_background)))
        else $error("stalled result changed");

endmodule

bind text_console_writer_unit tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (.*);

/* tb/tb_top.sv */
// Self-checking testbench of the text console writer: directed table, then random requests.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tcw_pkg::*;

    localparam int SCREEN   = C_ROWS * C_COLUMNS;
    localparam int ROW_W    = $clog2(C_ROWS);
    localparam int COL_W    = $clog2(C_COLUMNS);
    localparam int POS_W    = $clog2(SCREEN);
    localparam int CUR_W    = $clog2(SCREEN + 1);
    localparam int PHASES        = 6;
    localparam int PHASE_LEN     = 100;
    localparam int LONG_HOLD_AT  = 150;
    localparam int LONG_HOLD     = 400;
    localparam int WATCHDOG_LIMIT = 50000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int DIRECTED_LEN  = 26;

    typedef struct packed {
        t_kind              kind;
        logic [C_CHAR_W-1:0] code;
        logic [ROW_W-1:0]    row;
        logic [COL_W-1:0]    col;
        logic [POS_W-1:0]    pos;
    } t_op;

    typedef struct packed {
        logic [CUR_W-1:0]     cursor;
        logic [C_CHAR_W-1:0]  ch;
        logic [C_COLOR_W-1:0] fg;
        logic [C_COLOR_W-1:0] bg;
    } t_view;

    typedef struct packed {
        t_op   op;
        logic  typed;
        t_view want;
    } t_step;

    // Cursor starts at zero with reset colours (fg 15, bg 0).
    localparam t_step DIRECTED [DIRECTED_LEN] = '{
        '{'{K_NOP,         8'h00, 5'd0,  7'd0,   11'd0},    1'b1, '{11'd0,    8'h00, 4'h0, 4'h0}},
        '{'{K_WRITE,       8'h41, 5'd0,  7'd0,   11'd0},    1'b1, '{11'd1,    8'h00, 4'h0, 4'h0}},
        '{'{K_WRITE,       8'hFF, 5'd0,  7'd0,   11'd0},    1'b1, '{11'd2,    8'h00, 4'h0, 4'h0}},
        '{'{K_READ,        8'h00, 5'd0,  7'd0,   11'd0},    1'b1, '{11'd2,    8'h41, 4'hF, 4'h0}},
        '{'{K_READ,        8'h00, 5'd0,  7'd0,   11'd1},    1'b1, '{11'd2,    8'hFF, 4'hF, 4'h0}},
        '{'{K_READ,        8'h00, 5'd0,  7'd0,   11'd2047}, 1'b1, '{11'd2,    8'h00, 4'h0, 4'h0}},
        '{'{K_WRITE,       8'h0A, 5'd0,  7'd0,   11'd0},    1'b1, '{11'd80,   8'h00, 4'h0, 4'h0}},
        '{'{K_MOVE_RC,     8'h00, 5'd24, 7'd79,  11'd0},    1'b1, '{11'd1999, 8'h00, 4'h0, 4'h0}},
        '{'{K_MOVE_RC,     8'h00, 5'd31, 7'd127, 11'd0},    1'b1, '{11'd2000, 8'h00, 4'h0, 4'h0}},
        '{'{K_MOVE_ABS,    8'h00, 5'd0,  7'd0,   11'd2047}, 1'b1, '{11'd2000, 8'h00, 4'h0, 4'h0}},
        '{'{K_CLEAR,       8'h00, 5'd0,  7'd0,   11'd0},    1'b1, '{11'd0,    8'h00, 4'h0, 4'h0}},
        '{'{K_READ,        8'h00, 5'd0,  7'd0,   11'd1999}, 1'b1, '{11'd0,    8'h00, 4'hF, 4'h0}},
        '{'{K_FILL_ROW,    8'h5A, 5'd24, 7'd0,   11'd0},    1'b0, '0},
        '{'{K_READ,        8'h00, 5'd0,  7'd0,   11'd1920}, 1'b1, '{11'd0,    8'h5A, 4'hF, 4'h0}},
        '{'{K_FILL_ROW,    8'h77, 5'd25, 7'd0,   11'd0},    1'b1, '{11'd0,    8'h00, 4'h0, 4'h0}},
        '{'{K_FILL_ROW,    8'h77, 5'd31, 7'd0,   11'd0},    1'b1, '{11'd0,    8'h00, 4'h0, 4'h0}},
        '{'{K_READ,        8'h00, 5'd0,  7'd0,   11'd1920}, 1'b1, '{11'd0,    8'h5A, 4'hF, 4'h0}},
        '{'{K_FILL_SCREEN, 8'hFF, 5'd0,  7'd0,   11'd0},    1'b0, '0},
        '{'{K_MOVE_ABS,    8'h00, 5'd0,  7'd0,   11'd1999}, 1'b0, '0},
        '{'{K_WRITE,       8'h00, 5'd0,  7'd0,   11'd0},    1'b1, '{11'd2000, 8'h00, 4'h0, 4'h0}},
        '{'{K_WRITE,       8'h31, 5'd0,  7'd0,   11'd0},    1'b1, '{11'd1921, 8'h00, 4'h0, 4'h0}},
        '{'{K_READ,        8'h00, 5'd0,  7'd0,   11'd1920}, 1'b1, '{11'd1921, 8'h31, 4'hF, 4'h0}},
        '{'{K_READ,        8'h00, 5'd0,  7'd0,   11'd1919}, 1'b1, '{11'd1921, 8'h00, 4'hF, 4'h0}},
        '{'{K_MOVE_ABS,    8'h00, 5'd0,  7'd0,   11'd2000}, 1'b0, '0},
        '{'{K_WRITE,       8'h0A, 5'd0,  7'd0,   11'd0},    1'b1, '{11'd1920, 8'h00, 4'h0, 4'h0}},
        '{'{K_READ,        8'h00, 5'd0,  7'd0,   11'd1921}, 1'b1, '{11'd1920, 8'h00, 4'h0, 4'h0}}
    };

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_stall;
    logic [C_KIND_W-1:0]    i_kind;
    logic [C_CHAR_W-1:0]    i_char_code;
    logic [ROW_W-1:0]       i_row;
    logic [COL_W-1:0]       i_column;
    logic [POS_W-1:0]       i_position;
    logic                   o_out_valid;
    logic                   i_out_stall;
    logic [CUR_W-1:0]       o_cursor_position;
    logic [C_CHAR_W-1:0]    o_cell_char;
    logic [C_COLOR_W-1:0]   o_cell_foreground;
    logic [C_COLOR_W-1:0]   o_cell_background;
    logic                   i_cfg_we;
    logic [C_CFG_IDX_W-1:0] i_cfg_index;
    logic [C_COLOR_W-1:0]   i_cfg_data;

    t_cell                shadow_screen [SCREEN];
    int                   shadow_cursor;
    logic [C_COLOR_W-1:0] shadow_fg;
    logic [C_COLOR_W-1:0] shadow_bg;
    t_view                awaited_views [$];
    int                   bad_results;
    int                   views_seen;
    bit                   quiet;

    always #10 i_clk = ~i_clk;

    text_console_writer_unit i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_kind            (i_kind),
        .i_char_code       (i_char_code),
        .i_row             (i_row),
        .i_column          (i_column),
        .i_position        (i_position),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_cursor_position (o_cursor_position),
        .o_cell_char       (o_cell_char),
        .o_cell_foreground (o_cell_foreground),
        .o_cell_background (o_cell_background),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    function automatic void paint_rows(input int first, input int last,
                                       input logic [C_CHAR_W-1:0] code);
        int i;
        for (i = first * C_COLUMNS; i < (last + 1) * C_COLUMNS; i++) begin
            shadow_screen[i] = '{code, shadow_fg, shadow_bg};
        end
    endfunction

    function automatic t_view run_console_op(input t_op op);
        t_view v;
        int    i;
        int    target;
        v = '0;
        case (op.kind)
            K_WRITE: begin
                if (op.code == C_NEWLINE) begin
                    shadow_cursor += C_COLUMNS - shadow_cursor % C_COLUMNS;
                end
                // scroll up, blanking the bottom line to zeros
                while (shadow_cursor >= SCREEN) begin
                    for (i = 0; i < SCREEN - C_COLUMNS; i++) begin
                        shadow_screen[i] = shadow_screen[i + C_COLUMNS];
                    end
                    for (i = SCREEN - C_COLUMNS; i < SCREEN; i++) begin
                        shadow_screen[i] = '0;
                    end
                    shadow_cursor -= C_COLUMNS;
                end
                if (op.code != C_NEWLINE) begin
                    shadow_screen[shadow_cursor] = '{op.code, shadow_fg, shadow_bg};
                    shadow_cursor++;
                end
            end
            K_MOVE_RC: begin
                target = int'(op.row) * C_COLUMNS + int'(op.col);
                shadow_cursor = (target > SCREEN) ? SCREEN : target;
            end
            K_MOVE_ABS: begin
                target = int'(op.pos);
                shadow_cursor = (target > SCREEN) ? SCREEN : target;
            end
            K_FILL_SCREEN: paint_rows(0, C_ROWS - 1, op.code);
            K_FILL_ROW: begin
                if (int'(op.row) < C_ROWS) begin
                    paint_rows(int'(op.row), int'(op.row), op.code);
                end
            end
            K_CLEAR: begin
                paint_rows(0, C_ROWS - 1, '0);
                shadow_cursor = 0;
            end
            K_READ: begin
                if (int'(op.pos) < SCREEN) begin
                    v.ch = shadow_screen[op.pos].code;
                    v.fg = shadow_screen[op.pos].fg;
                    v.bg = shadow_screen[op.pos].bg;
                end
            end
            default: ;
        endcase
        v.cursor = CUR_W'(shadow_cursor);
        return v;
    endfunction

    function automatic t_op random_op();
        t_op o;
        int  pick;
        o.kind = K_NOP;
        o.code = C_CHAR_W'($urandom_range(0, 255));
        o.row  = ROW_W'($urandom_range(0, 31));
        o.col  = COL_W'($urandom_range(0, 127));
        o.pos  = ($urandom_range(0, 3) == 0) ? POS_W'($urandom_range(1985, 2047))
                                             : POS_W'($urandom_range(0, 2047));
        pick   = $urandom_range(0, 99);
        if (pick < 45) begin
            o.kind = K_WRITE;
            if ($urandom_range(0, 15) == 0) begin
                o.code = C_NEWLINE;
            end
        end else if (pick < 55) begin
            o.kind = K_MOVE_RC;
        end else if (pick < 67) begin
            o.kind = K_MOVE_ABS;
        end else if (pick < 69) begin
            o.kind = K_FILL_SCREEN;
        end else if (pick < 75) begin
            o.kind = K_FILL_ROW;
        end else if (pick < 76) begin
            o.kind = K_CLEAR;
        end else if (pick < 96) begin
            o.kind = K_READ;
        end
        return o;
    endfunction

    task automatic offer_request(input t_op op, input logic typed, input t_view want);
        t_view v;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_kind      <= op.kind;
        i_char_code <= op.code;
        i_row       <= op.row;
        i_column    <= op.col;
        i_position  <= op.pos;
        do @(posedge i_clk); while (o_in_stall);
        v = run_console_op(op);
        awaited_views.push_back(typed ? want : v);
    endtask

    task automatic set_colors(input logic [C_COLOR_W-1:0] fg, input logic [C_COLOR_W-1:0] bg);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_FOREGROUND;
        i_cfg_data  <= fg;
        @(posedge i_clk);
        i_cfg_index <= CFG_BACKGROUND;
        i_cfg_data  <= bg;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        shadow_fg = fg;
        shadow_bg = bg;
    endtask

    initial begin : stimulus
        int n;
        int phase;
        bad_results   = 0;
        views_seen    = 0;
        quiet         = 1'b0;
        shadow_cursor = 0;
        shadow_fg     = C_FG_RESET;
        shadow_bg     = C_BG_RESET;
        for (n = 0; n < SCREEN; n++) begin
            shadow_screen[n] = '0;
        end
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_kind      <= K_NOP;
        i_char_code <= '0;
        i_row       <= '0;
        i_column    <= '0;
        i_position  <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_FOREGROUND;
        i_cfg_data  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (n = 0; n < DIRECTED_LEN; n++) begin
            offer_request(DIRECTED[n].op, DIRECTED[n].typed, DIRECTED[n].want);
        end

        for (phase = 0; phase < PHASES; phase++) begin
            // colours change only with nothing in flight
            i_in_valid <= 1'b0;
            while (awaited_views.size() != 0) @(posedge i_clk);
            case (phase)
                0:       set_colors(4'h0, 4'hF);
                1:       set_colors(4'hF, 4'h0);
                default: set_colors(C_COLOR_W'($urandom_range(0, 15)),
                                    C_COLOR_W'($urandom_range(0, 15)));
            endcase
            quiet = (phase == PHASES - 1);
            for (n = 0; n < PHASE_LEN; n++) begin
                offer_request(random_op(), 1'b0, '0);
            end
        end

        i_in_valid <= 1'b0;
        while (awaited_views.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (bad_results == 0) begin
            $display("[text_console_writer_unit] OK");
        end else begin
            $display("[text_console_writer_unit] ERROR");
        end
        $finish;
    end

    initial begin : result_sink
        int    stall_left;
        bit    held_long;
        t_view got;
        t_view want;
        stall_left = 0;
        held_long  = 1'b0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                got = '{o_cursor_position, o_cell_char, o_cell_foreground, o_cell_background};
                views_seen++;
                if (awaited_views.size() == 0) begin
                    bad_results++;
                    if (bad_results <= 10) begin
                        $display("unexpected result: cursor %0d char %h fg %h bg %h",
                                 got.cursor, got.ch, got.fg, got.bg);
                    end
                end else begin
                    want = awaited_views.pop_front();
                    if (got.cursor !== want.cursor || got.ch !== want.ch ||
                        got.fg !== want.fg || got.bg !== want.bg) begin
                        bad_results++;
                        if (bad_results <= 10) begin
                            $display("result %0d: expected %0d/%h/%h/%h, got %0d/%h/%h/%h",
                                     views_seen, want.cursor, want.ch, want.fg, want.bg,
                                     got.cursor, got.ch, got.fg, got.bg);
                        end
                    end
                end
            end
            // one long hold-off so the block fills up and stalls its request side
            if (views_seen == LONG_HOLD_AT && !held_long) begin
                held_long  = 1'b1;
                stall_left = LONG_HOLD;
            end else if (stall_left == 0 && !quiet && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 15);
            end
            if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("[text_console_writer_unit] ERROR");
        $finish;
    end

endmodule
